// ===== hdl/hysteretic_top_k_source_selector_macros.svh =====
// assertion macros of the checker file
// no dependencies; included by bare file name
`ifndef HYSTERETIC_TOP_K_SOURCE_SELECTOR_MACROS_SVH
`define HYSTERETIC_TOP_K_SOURCE_SELECTOR_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define HTKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is held
`define HTKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/htks_pkg.sv =====
// types and constants of the camera source selector
// no dependencies; used by the interfaces, the divider and the top level
`timescale 1ns / 1ps
package htks_pkg;

	localparam int NUM_CAMERAS_DEF = 16;
	localparam int MODE_W = 2;
	localparam int CAM_W = 4;
	localparam int SCORE_W = 16;
	localparam int TOPK_W = 5;
	localparam int DECAY_W = 17;
	localparam int MAF_W = 8;
	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam int MAX_SEL = 16;
	localparam int SEL_IDX_W = 4;
	localparam int SEL_CNT_W = 5;
	localparam int SUM_W = 20;
	localparam int FRAC_W = 12;

	localparam logic [DECAY_W-1:0] DECAY_ONE = 17'd65536;
	localparam logic [DECAY_W-1:0] SWITCH_ONE = 17'd4096;

	// reset values of the registers
	localparam logic [TOPK_W-1:0] TOP_K_RST = 5'd4;
	localparam logic [SCORE_W-1:0] THRESH_RST = 16'd328;
	localparam logic [DECAY_W-1:0] DECAY_RST = 17'd58982;
	localparam logic [MAF_W-1:0] MAF_RST = 8'd5;
	localparam logic [SCORE_W-1:0] SWITCH_RST = 16'd819;

	typedef enum logic [MODE_W-1:0] {
		MODE_STORE = 2'd0,
		MODE_ROUND = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOP_K     = 3'd0,
		CFG_THRESHOLD = 3'd1,
		CFG_DECAY     = 3'd2,
		CFG_MIN_FRAME = 3'd3,
		CFG_SWITCH    = 3'd4
	} cfg_reg_t;

	// request to the divider
	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] dividend;
		logic [SEL_CNT_W-1:0] divisor;
	} div_req_t;

	// answer of the divider
	typedef struct packed {
		logic done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/htks_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on htks_pkg
`timescale 1ns / 1ps
interface htks_item_if;
	import htks_pkg::*;
	logic valid;
	logic ready;
	logic [MODE_W-1:0] mode;
	logic [CAM_W-1:0] camera_index;
	logic [SCORE_W-1:0] motion_score;

	modport source (output valid, mode, camera_index, motion_score, input ready);
	modport sink (input valid, mode, camera_index, motion_score, output ready);
endinterface

interface htks_result_if;
	import htks_pkg::*;
	logic valid;
	logic ready;
	logic [CAM_W-1:0] selected_camera;
	logic entry_valid;
	logic [SCORE_W-1:0] average_score;
	logic last_entry;

	modport source (output valid, selected_camera, entry_valid, average_score, last_entry,
		input ready);
	modport sink (input valid, selected_camera, entry_valid, average_score, last_entry,
		output ready);
endinterface

// ===== hdl/htks_div.sv =====
// restoring divider, one quotient bit per cycle, for the round average
// depends on htks_pkg
`timescale 1ns / 1ps
module htks_div (
	input  logic clk,
	input  logic arst_n,
	input  htks_pkg::div_req_t req,
	output htks_pkg::div_rsp_t rsp
);
	import htks_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [SEL_CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [SEL_CNT_W-1:0] div_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [SEL_CNT_W:0] rem_sh;
	logic fits;

	// one trial subtraction
	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign fits = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= STEP_W'(SUM_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? SEL_CNT_W'(rem_sh - {1'b0, div_q}) : rem_sh[SEL_CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ===== hdl/hysteretic_top_k_source_selector.sv =====
// Hysteretic top-k camera source selector.
// Input channel item: mode 0 stores one camera's raw score, mode 2 clears all
// camera state, mode 1 runs one selection round, mode 3 is ignored.
// Result channel: one transaction per selected camera in selection order, each
// carrying the round's truncated mean raw score; last_entry marks the final one.
// A round that selects nothing gives one transaction with entry_valid low.
// Store, clear and ignored items give no result and leave the block idle.
// After a round item is accepted, the update scan, the ranking steps with their
// weakest-active searches, the commit scan and the division run in turn; then
// results follow one per cycle while the receiver takes them. A ranking step
// whose camera is already selected skips the weakest-active search, and an
// empty round skips the division.
// A single scan pointer visits one camera per cycle for the update, each maximum
// search, each weakest-active search and the commit; the average comes from a
// bit-serial divider. Input ready is high only while no item is in progress.
// When the receiver stalls, the current result holds until taken.
// Reset clears all camera state and loads the register defaults. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce.
// depends on htks_pkg, htks_if, htks_div
`timescale 1ns / 1ps
module hysteretic_top_k_source_selector #(
	parameter int NUM_CAMERAS = htks_pkg::NUM_CAMERAS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	htks_item_if.sink item,
	htks_result_if.source result,
	input  logic cfg_we,
	input  logic [htks_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [htks_pkg::CFG_DATA_W-1:0] cfg_data
);
	import htks_pkg::*;

	localparam int IDX_W = $clog2(NUM_CAMERAS);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_UPD   = 9'b000000010,
		ST_RANK  = 9'b000000100,
		ST_RDONE = 9'b000001000,
		ST_LOW   = 9'b000010000,
		ST_LDONE = 9'b000100000,
		ST_SUM   = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_EMIT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [TOPK_W-1:0] top_k_q;
	logic [SCORE_W-1:0] thresh_q;
	logic [DECAY_W-1:0] decay_q;
	logic [MAF_W-1:0] maf_q;
	logic [SCORE_W-1:0] switch_q;

	logic [SCORE_W-1:0] raw_q [NUM_CAMERAS];
	logic [SCORE_W-1:0] dec_q [NUM_CAMERAS];
	logic [CNT_W-1:0] cnt_q [NUM_CAMERAS];
	logic [NUM_CAMERAS-1:0] active_q;
	logic [NUM_CAMERAS-1:0] left_q;
	logic [NUM_CAMERAS-1:0] insel_q;
	logic [IDX_W-1:0] sel_list_q [MAX_SEL];
	logic [SEL_CNT_W-1:0] nsel_q;
	logic [IDX_W-1:0] ptr_q;
	logic found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [SCORE_W-1:0] best_score_q;
	logic lfound_q;
	logic [IDX_W-1:0] low_idx_q;
	logic [SCORE_W-1:0] low_score_q;
	logic [SUM_W-1:0] sum_q;
	logic [SCORE_W-1:0] avg_q;
	logic [SEL_IDX_W-1:0] ocnt_q;

	logic ptr_last;
	logic [DECAY_W-1:0] df;
	logic [TOPK_W-1:0] kk;
	logic [SCORE_W-1:0] mul_a;
	logic [DECAY_W-1:0] mul_b;
	logic [SCORE_W+DECAY_W-1:0] product;
	logic [DECAY_W-1:0] dprod;
	logic [SCORE_W-1:0] dsat;
	logic [SCORE_W-1:0] dnew;
	logic [SCORE_W-1:0] upd_score;
	logic [CNT_W-1:0] upd_cnt;
	logic prot;
	logic switch_win;
	logic sel_full;
	logic push_en;
	logic [IDX_W-1:0] push_idx;
	logic [SUM_W-1:0] sum_n;
	logic item_acc;
	logic res_acc;
	logic res_last;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign ptr_last = ptr_q == IDX_W'(NUM_CAMERAS - 1);
	assign df = (decay_q > DECAY_ONE) ? DECAY_ONE : decay_q;
	assign kk = (top_k_q > TOPK_W'(MAX_SEL)) ? TOPK_W'(MAX_SEL) : top_k_q;
	assign item_acc = item.valid && item.ready;
	assign res_acc = result.valid && result.ready;

	// shared multiplier: decay during update, switch margin otherwise
	assign mul_a = (state_q == ST_UPD) ? dec_q[ptr_q] : low_score_q;
	assign mul_b = (state_q == ST_UPD) ? df : SWITCH_ONE + DECAY_W'(switch_q);
	assign product = (SCORE_W + DECAY_W)'(mul_a) * (SCORE_W + DECAY_W)'(mul_b);

	// per-camera update of score and active count
	assign dprod = product[SCORE_W+DECAY_W-1:SCORE_W];
	assign dsat = (dprod > DECAY_W'(16'hFFFF)) ? 16'hFFFF : dprod[SCORE_W-1:0];
	assign dnew = (raw_q[ptr_q] > dsat) ? raw_q[ptr_q] : dsat;
	assign upd_score = active_q[ptr_q] ? raw_q[ptr_q] : dnew;
	always_comb begin
		upd_cnt = '0;
		if (active_q[ptr_q])
			upd_cnt = (cnt_q[ptr_q] == '1) ? cnt_q[ptr_q] : cnt_q[ptr_q] + 1'b1;
	end
	assign prot = active_q[ptr_q] && (upd_cnt < maf_q);

	// candidate beats weakest active camera by the margin, full-width compare
	assign switch_win = (SCORE_W + DECAY_W)'({best_score_q, FRAC_W'(0)}) > product;
	assign sel_full = (nsel_q >= kk) || (nsel_q >= SEL_CNT_W'(MAX_SEL));

	// additions to the selection list
	always_comb begin
		push_en = 1'b0;
		push_idx = ptr_q;
		if (state_q == ST_UPD) begin
			push_en = prot && (nsel_q < SEL_CNT_W'(MAX_SEL));
		end else if (state_q == ST_LDONE) begin
			push_en = 1'b1;
			push_idx = (!lfound_q || switch_win) ? best_idx_q : low_idx_q;
		end
	end

	// average: sum of raw scores of the selected cameras
	assign sum_n = sum_q + (insel_q[ptr_q] ? SUM_W'(raw_q[ptr_q]) : '0);
	assign div_req.start = (state_q == ST_SUM) && ptr_last && (nsel_q != '0);
	assign div_req.dividend = sum_n;
	assign div_req.divisor = nsel_q;

	htks_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= TOP_K_RST;
			thresh_q <= THRESH_RST;
			decay_q <= DECAY_RST;
			maf_q <= MAF_RST;
			switch_q <= SWITCH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOP_K:     top_k_q <= cfg_data[TOPK_W-1:0];
				CFG_THRESHOLD: thresh_q <= cfg_data[SCORE_W-1:0];
				CFG_DECAY:     decay_q <= cfg_data;
				CFG_MIN_FRAME: maf_q <= cfg_data[MAF_W-1:0];
				CFG_SWITCH:    switch_q <= cfg_data[SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_CAMERAS; i++) begin
				raw_q[i] <= '0;
				dec_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			for (int i = 0; i < MAX_SEL; i++)
				sel_list_q[i] <= '0;
			active_q <= '0;
			left_q <= '0;
			insel_q <= '0;
			nsel_q <= '0;
			ptr_q <= '0;
			found_q <= 1'b0;
			best_idx_q <= '0;
			best_score_q <= '0;
			lfound_q <= 1'b0;
			low_idx_q <= '0;
			low_score_q <= '0;
			sum_q <= '0;
			avg_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (push_en) begin
				sel_list_q[nsel_q[SEL_IDX_W-1:0]] <= push_idx;
				insel_q[push_idx] <= 1'b1;
				nsel_q <= nsel_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						unique case (item.mode)
							MODE_STORE: begin
								if (32'(item.camera_index) < NUM_CAMERAS)
									raw_q[IDX_W'(item.camera_index)] <= item.motion_score;
							end
							MODE_CLEAR: begin
								for (int i = 0; i < NUM_CAMERAS; i++) begin
									raw_q[i] <= '0;
									dec_q[i] <= '0;
									cnt_q[i] <= '0;
								end
								active_q <= '0;
							end
							MODE_ROUND: begin
								state_q <= ST_UPD;
								ptr_q <= '0;
								nsel_q <= '0;
								insel_q <= '0;
								sum_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_UPD: begin
					dec_q[ptr_q] <= upd_score;
					cnt_q[ptr_q] <= upd_cnt;
					left_q[ptr_q] <= upd_score >= thresh_q;
					if (ptr_last) begin
						ptr_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_RANK;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				// search for the highest remaining candidate
				ST_RANK: begin
					if (left_q[ptr_q] && (!found_q || dec_q[ptr_q] > best_score_q)) begin
						found_q <= 1'b1;
						best_idx_q <= ptr_q;
						best_score_q <= dec_q[ptr_q];
					end
					if (ptr_last) begin
						ptr_q <= '0;
						state_q <= ST_RDONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_RDONE: begin
					found_q <= 1'b0;
					lfound_q <= 1'b0;
					ptr_q <= '0;
					if (!found_q || sel_full) begin
						state_q <= ST_SUM;
					end else begin
						left_q[best_idx_q] <= 1'b0;
						state_q <= insel_q[best_idx_q] ? ST_RANK : ST_LOW;
					end
				end
				// search for the weakest unprotected active camera
				ST_LOW: begin
					if (active_q[ptr_q] && !insel_q[ptr_q] &&
						(!lfound_q || dec_q[ptr_q] < low_score_q)) begin
						lfound_q <= 1'b1;
						low_idx_q <= ptr_q;
						low_score_q <= dec_q[ptr_q];
					end
					if (ptr_last) begin
						ptr_q <= '0;
						state_q <= ST_LDONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_LDONE: begin
					found_q <= 1'b0;
					state_q <= ST_RANK;
				end
				// commit the active set and sum the raw scores
				ST_SUM: begin
					active_q[ptr_q] <= insel_q[ptr_q];
					if (!insel_q[ptr_q])
						cnt_q[ptr_q] <= '0;
					sum_q <= sum_n;
					if (ptr_last) begin
						ptr_q <= '0;
						ocnt_q <= '0;
						if (nsel_q == '0) begin
							avg_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIV;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						avg_q <= div_rsp.quotient[SCORE_W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_acc) begin
						if (res_last)
							state_q <= ST_IDLE;
						else
							ocnt_q <= ocnt_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// channel outputs
	assign item.ready = state_q == ST_IDLE;
	assign res_last = (nsel_q == '0) || (SEL_CNT_W'(ocnt_q) == nsel_q - 1'b1);
	assign result.valid = state_q == ST_EMIT;
	assign result.entry_valid = nsel_q != '0;
	assign result.selected_camera = (nsel_q == '0) ? '0 : CAM_W'(sel_list_q[ocnt_q]);
	assign result.average_score = avg_q;
	assign result.last_entry = res_last;
endmodule

// ===== hdl/htks_checker.sv =====
// port-level checks of the camera source selector, bound to the top level
// depends on hysteretic_top_k_source_selector_macros.svh
`timescale 1ns / 1ps
`include "hysteretic_top_k_source_selector_macros.svh"
module htks_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_entry_valid,
	input logic out_last_entry
);
	// no new item is taken while results are pending
	`HTKS_ASSERT_NOW(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input ready while result pending")
	// an empty selection is the whole round
	`HTKS_ASSERT_NOW(a_empty_last, clk, arst_n, out_valid && !out_entry_valid, out_last_entry, "empty result not last")
	// the round ends after its last transaction
	`HTKS_ASSERT_NEXT(a_round_end, clk, arst_n, out_valid && out_ready && out_last_entry, !out_valid, "result after last entry")
	// a stalled result is not withdrawn
	`HTKS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped under stall")
endmodule

bind hysteretic_top_k_source_selector htks_checker u_htks_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_entry_valid(result.entry_valid),
	.out_last_entry(result.last_entry)
);

// ===== verif/tb.sv =====
// testbench for the hysteretic top-k camera source selector: directed, register and random tests
// predicts every selection round in place and checks each result transaction in order
// depends on htks_pkg, htks_if and the selector rtl
`timescale 1ns / 1ps
module tb;
	import htks_pkg::*;

	localparam int NCAM = 16;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [CAM_W-1:0] cam;
		logic ev;
		logic [SCORE_W-1:0] avg;
		logic last;
	} selection_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	htks_item_if item ();
	htks_result_if result ();

	hysteretic_top_k_source_selector dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predicted camera state and registers
	logic [SCORE_W-1:0] raw_q [NCAM];
	logic [SCORE_W-1:0] dec_q [NCAM];
	bit act_q [NCAM];
	logic [CNT_W-1:0] cnt_q [NCAM];
	int unsigned top_k_q, thresh_q, decay_q, maf_q, switch_q;

	selection_t pending_sel [$];
	int errors = 0;
	int src_idle;
	int snk_idle;
	longint cycles = 0;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void clear_cams();
		for (int i = 0; i < NCAM; i++) begin
			raw_q[i] = '0;
			dec_q[i] = '0;
			act_q[i] = 0;
			cnt_q[i] = '0;
		end
	endfunction

	function automatic bit in_sel(int q [$], int id);
		foreach (q[i])
			if (q[i] == id)
				return 1;
		return 0;
	endfunction

	// one selection round on the predicted state
	function automatic void predict_round();
		int ranked [$];
		int sel [$];
		bit used [NCAM];
		int best, low, cam;
		int unsigned k, df, sum, avg;
		longint unsigned d, lhs, rhs;
		selection_t s;
		k = (top_k_q > MAX_SEL) ? MAX_SEL : top_k_q;
		df = (decay_q > 65536) ? 65536 : decay_q;
		// score and count update
		for (int i = 0; i < NCAM; i++) begin
			if (act_q[i]) begin
				dec_q[i] = raw_q[i];
				if (cnt_q[i] != 8'd255)
					cnt_q[i] = cnt_q[i] + 8'd1;
			end else begin
				d = (longint'(dec_q[i]) * df) >> 16;
				if (d > 65535)
					d = 65535;
				if (raw_q[i] > d)
					d = raw_q[i];
				dec_q[i] = 16'(d);
				cnt_q[i] = '0;
			end
		end
		// ranking, ties to the lower index
		for (int i = 0; i < NCAM; i++)
			used[i] = !(dec_q[i] >= thresh_q);
		forever begin
			best = -1;
			for (int i = 0; i < NCAM; i++)
				if (!used[i] && (best < 0 || dec_q[i] > dec_q[best]))
					best = i;
			if (best < 0)
				break;
			used[best] = 1;
			ranked = {ranked, best};
		end
		// protected active cameras
		for (int i = 0; i < NCAM; i++)
			if (act_q[i] && cnt_q[i] < maf_q && sel.size() < MAX_SEL)
				sel = {sel, i};
		// fill with the switch test
		foreach (ranked[r]) begin
			cam = ranked[r];
			low = -1;
			if (sel.size() >= k || sel.size() >= MAX_SEL)
				break;
			if (in_sel(sel, cam))
				continue;
			for (int i = 0; i < NCAM; i++) begin
				if (!act_q[i] || in_sel(sel, i))
					continue;
				if (low < 0 || dec_q[i] < dec_q[low])
					low = i;
			end
			if (low >= 0) begin
				lhs = longint'(dec_q[cam]) * 4096;
				rhs = longint'(dec_q[low]) * (4096 + switch_q);
				sel = {sel, ((lhs > rhs) ? cam : low)};
			end else begin
				sel = {sel, cam};
			end
		end
		// commit the active set
		for (int i = 0; i < NCAM; i++) begin
			act_q[i] = in_sel(sel, i);
			if (!act_q[i])
				cnt_q[i] = '0;
		end
		if (sel.size() == 0) begin
			s.cam = '0;
			s.ev = 0;
			s.avg = '0;
			s.last = 1;
			pending_sel = {pending_sel, s};
			return;
		end
		sum = 0;
		foreach (sel[i])
			sum += raw_q[sel[i]];
		avg = sum / sel.size();
		foreach (sel[i]) begin
			s.cam = 4'(sel[i]);
			s.ev = 1;
			s.avg = 16'(avg);
			s.last = (i == sel.size() - 1);
			pending_sel = {pending_sel, s};
		end
	endfunction

	// send one item and update the prediction on acceptance
	task automatic send_item(mode_t m, logic [CAM_W-1:0] c, logic [SCORE_W-1:0] s);
		if ($urandom_range(99) < src_idle) begin
			item.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle)
				@(posedge clk);
		end
		item.valid <= 1'b1;
		item.mode <= m;
		item.camera_index <= c;
		item.motion_score <= s;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		case (m)
			MODE_STORE: raw_q[c] = s;
			MODE_ROUND: predict_round();
			MODE_CLEAR: clear_cams();
			default: ;
		endcase
	endtask

	// wait until nothing is expected, then let the block settle
	task automatic drain();
		item.valid <= 1'b0;
		while (pending_sel.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TOP_K: top_k_q = v[TOPK_W-1:0];
			CFG_THRESHOLD: thresh_q = v[SCORE_W-1:0];
			CFG_DECAY: decay_q = v[DECAY_W-1:0];
			CFG_MIN_FRAME: maf_q = v[MAF_W-1:0];
			CFG_SWITCH: switch_q = v[SCORE_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [SCORE_W-1:0] rand_score();
		case ($urandom_range(5))
			0: return 16'hFFFF;
			1: return '0;
			2: return 16'($urandom_range(200, 500));
			default: return 16'($urandom);
		endcase
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (pending_sel.size() == 0) begin
				$error("unexpected result transaction camera=%0d", result.selected_camera);
				errors++;
			end else begin
				selection_t e;
				e = pending_sel.pop_front();
				if (result.selected_camera !== e.cam) begin
					$error("selected_camera exp %0d got %0d", e.cam, result.selected_camera);
					errors++;
				end
				if (result.entry_valid !== e.ev) begin
					$error("entry_valid exp %0d got %0d", e.ev, result.entry_valid);
					errors++;
				end
				if (result.average_score !== e.avg) begin
					$error("average_score exp %0d got %0d", e.avg, result.average_score);
					errors++;
				end
				if (result.last_entry !== e.last) begin
					$error("last_entry exp %0d got %0d", e.last, result.last_entry);
					errors++;
				end
			end
		end
		result.ready <= ($urandom_range(99) >= snk_idle);
	end

	// extremes of the fields, every mode, ignored items and empty rounds
	task automatic test_directed();
		send_item(MODE_ROUND, 4'd0, 16'd0);
		send_item(MODE_STORE, 4'd0, 16'hFFFF);
		send_item(MODE_STORE, 4'd15, 16'hFFFF);
		send_item(MODE_STORE, 4'd5, 16'd328);
		send_item(MODE_STORE, 4'd6, 16'd327);
		send_item(MODE_STORE, 4'd10, 16'h5555);
		send_item(MODE_NONE, 4'd3, 16'hAAAA);
		send_item(MODE_ROUND, 4'd15, 16'hFFFF);
		send_item(MODE_ROUND, 4'd0, 16'd0);
		send_item(MODE_STORE, 4'd0, 16'd0);
		send_item(MODE_STORE, 4'd3, 16'h8000);
		send_item(MODE_ROUND, 4'd0, 16'd0);
		send_item(MODE_ROUND, 4'd0, 16'd0);
		send_item(MODE_CLEAR, 4'd15, 16'hFFFF);
		send_item(MODE_ROUND, 4'd0, 16'd0);
		send_item(MODE_STORE, 4'd9, 16'd1000);
		send_item(MODE_STORE, 4'd8, 16'd1000);
		send_item(MODE_ROUND, 4'd0, 16'd0);
		send_item(MODE_NONE, 4'd15, 16'hFFFF);
		send_item(MODE_ROUND, 4'd0, 16'd0);
	endtask

	// the given number of rounds of scores under the current registers
	task automatic run_rounds(int n);
		for (int r = 0; r < n; r++) begin
			repeat ($urandom_range(1, 6))
				send_item(MODE_STORE, 4'($urandom_range(15)), rand_score());
			send_item(MODE_ROUND, 4'($urandom), 16'($urandom));
		end
	endtask

	// register settings including the extremes and the saturating values
	task automatic test_registers();
		write_reg(CFG_TOP_K, 17'd16);
		write_reg(CFG_THRESHOLD, 17'd0);
		write_reg(CFG_MIN_FRAME, 17'd0);
		write_reg(CFG_SWITCH, 17'd0);
		write_reg(CFG_DECAY, 17'd65536);
		run_rounds(3);
		write_reg(CFG_TOP_K, 17'd31);
		write_reg(CFG_DECAY, 17'h1FFFF);
		write_reg(CFG_MIN_FRAME, 17'd255);
		run_rounds(3);
		write_reg(CFG_TOP_K, 17'd0);
		write_reg(CFG_THRESHOLD, 17'hFFFF);
		write_reg(CFG_DECAY, 17'd0);
		write_reg(CFG_SWITCH, 17'hFFFF);
		run_rounds(2);
		write_reg(CFG_TOP_K, 17'd1);
		write_reg(CFG_THRESHOLD, 17'd1);
		write_reg(CFG_MIN_FRAME, 17'd1);
		run_rounds(3);
		write_reg(CFG_TOP_K, 17'd4);
		write_reg(CFG_THRESHOLD, 17'd328);
		write_reg(CFG_DECAY, 17'd58982);
		write_reg(CFG_MIN_FRAME, 17'd5);
		write_reg(CFG_SWITCH, 17'd819);
	endtask

	// random traffic under random settings, with the idle pattern stepping through
	task automatic test_random();
		int sent;
		bit paused;
		sent = 0;
		paused = 0;
		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 15 : (phase == 1) ? 62 : 0;
			snk_idle = (phase == 0) ? 62 : (phase == 1) ? 15 : 0;
			write_reg(CFG_TOP_K, 17'($urandom_range(0, 20)));
			write_reg(CFG_THRESHOLD, 17'($urandom_range(0, 3)) == 0 ?
				17'($urandom) : 17'($urandom_range(0, 2000)));
			write_reg(CFG_DECAY, 17'($urandom));
			write_reg(CFG_MIN_FRAME, 17'($urandom_range(0, 8)));
			write_reg(CFG_SWITCH, 17'($urandom));
			for (int i = 0; i < 28; i++) begin
				if ($urandom_range(9) == 0)
					send_item(mode_t'(2'($urandom)), 4'($urandom), 16'($urandom));
				else if ($urandom_range(19) == 0)
					send_item(MODE_CLEAR, 4'($urandom), 16'($urandom));
				else
					run_rounds(1);
				if (!paused && i == 14) begin
					// hold off until the block has delivered everything
					paused = 1;
					item.valid <= 1'b0;
					while (pending_sel.size() != 0)
						@(posedge clk);
					@(posedge clk);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		src_idle = 15;
		snk_idle = 62;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.mode = MODE_STORE;
		item.camera_index = '0;
		item.motion_score = '0;
		top_k_q = TOP_K_RST;
		thresh_q = THRESH_RST;
		decay_q = DECAY_RST;
		maf_q = MAF_RST;
		switch_q = SWITCH_RST;
		clear_cams();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_random();
		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/htks_pkg.sv
hdl/htks_if.sv
hdl/htks_div.sv
hdl/hysteretic_top_k_source_selector.sv
hdl/htks_checker.sv
verif/tb.sv
